// ----- rtl/ptrt_pkg.sv -----
// Shared types and codes for the periodic task ready table.
`default_nettype none

package ptrt_pkg;

  // Fixed field widths
  localparam int OP_W     = 3;
  localparam int SLOT_W   = 4;
  localparam int HANDLE_W = 16;
  localparam int PERIOD_W = 16;
  localparam int MODE_W   = 2;

  // Operation codes
  localparam logic [OP_W-1:0] OP_ADD      = 3'd0;
  localparam logic [OP_W-1:0] OP_DELETE   = 3'd1;
  localparam logic [OP_W-1:0] OP_PEND     = 3'd2;
  localparam logic [OP_W-1:0] OP_RESUME   = 3'd3;
  localparam logic [OP_W-1:0] OP_TICK     = 3'd4;
  localparam logic [OP_W-1:0] OP_DISPATCH = 3'd5;

  // Slot modes
  localparam logic [MODE_W-1:0] MODE_DELETED = 2'd0;
  localparam logic [MODE_W-1:0] MODE_WAITING = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READY   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_PENDED  = 2'd3;

  // Memory port strobes from the sequencer
  typedef struct packed {
    logic rd_en;
    logic wr_a;
    logic wr_b;
  } mem_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/ptrt_slot_mem.sv -----
// Slot storage: mode/countdown memory and period/handle memory.
`default_nettype none

module ptrt_slot_mem #(
  parameter int NUM_SLOTS   = 16,
  parameter int COUNT_WIDTH = 16
) (
  input  wire                                        clk_i,
  input  wire ptrt_pkg::mem_ctrl_t                   mem_ctrl_i,
  input  wire [$clog2(NUM_SLOTS)-1:0]                rd_addr_i,
  input  wire [$clog2(NUM_SLOTS)-1:0]                wr_addr_i,
  input  wire [ptrt_pkg::MODE_W+COUNT_WIDTH-1:0]     wdata_a_i,
  input  wire [COUNT_WIDTH+ptrt_pkg::HANDLE_W-1:0]   wdata_b_i,
  output logic [ptrt_pkg::MODE_W+COUNT_WIDTH-1:0]    rdata_a_o,
  output logic [COUNT_WIDTH+ptrt_pkg::HANDLE_W-1:0]  rdata_b_o
);

  localparam int AW = ptrt_pkg::MODE_W + COUNT_WIDTH;
  localparam int BW = COUNT_WIDTH + ptrt_pkg::HANDLE_W;

  logic [AW-1:0] mem_a [NUM_SLOTS];
  logic [BW-1:0] mem_b [NUM_SLOTS];

  // {mode, countdown}
  always_ff @(posedge clk_i) begin
    if (mem_ctrl_i.wr_a) begin
      mem_a[wr_addr_i] <= wdata_a_i;
    end
    if (mem_ctrl_i.rd_en) begin
      rdata_a_o <= mem_a[rd_addr_i];
    end
  end

  // {period, handle}
  always_ff @(posedge clk_i) begin
    if (mem_ctrl_i.wr_b) begin
      mem_b[wr_addr_i] <= wdata_b_i;
    end
    if (mem_ctrl_i.rd_en) begin
      rdata_b_o <= mem_b[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/ptrt_ctrl.sv -----
// Command sequencer: slot updates, tick and dispatch sweeps, result register.
`default_nettype none

module ptrt_ctrl #(
  parameter int NUM_SLOTS   = 16,
  parameter int COUNT_WIDTH = 16
) (
  input  wire                                        clk_i,
  input  wire                                        rst_ni,
  input  wire                                        start_i,
  input  wire [ptrt_pkg::OP_W-1:0]                   operation_i,
  input  wire [ptrt_pkg::SLOT_W-1:0]                 slot_i,
  input  wire [ptrt_pkg::PERIOD_W-1:0]               period_i,
  input  wire [ptrt_pkg::HANDLE_W-1:0]               task_handle_i,
  output logic                                       busy_o,
  output logic                                       done_o,
  output logic                                       accepted_o,
  output logic [ptrt_pkg::SLOT_W-1:0]                ready_slot_o,
  output logic [ptrt_pkg::HANDLE_W-1:0]              ready_handle_o,
  output ptrt_pkg::mem_ctrl_t                        mem_ctrl_o,
  output logic [$clog2(NUM_SLOTS)-1:0]               rd_addr_o,
  output logic [$clog2(NUM_SLOTS)-1:0]               wr_addr_o,
  output logic [ptrt_pkg::MODE_W+COUNT_WIDTH-1:0]    wdata_a_o,
  output logic [COUNT_WIDTH+ptrt_pkg::HANDLE_W-1:0]  wdata_b_o,
  input  wire [ptrt_pkg::MODE_W+COUNT_WIDTH-1:0]     rdata_a_i,
  input  wire [COUNT_WIDTH+ptrt_pkg::HANDLE_W-1:0]   rdata_b_i
);

  localparam int IW   = $clog2(NUM_SLOTS);
  localparam int CNTW = $clog2(NUM_SLOTS + 1);
  localparam int CW   = COUNT_WIDTH;
  localparam int HW   = ptrt_pkg::HANDLE_W;
  localparam int MW   = ptrt_pkg::MODE_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_PR   = 2'd1;
  localparam logic [1:0] ST_TICK = 2'd2;
  localparam logic [1:0] ST_DISP = 2'd3;

  logic [1:0]                   state_q, state_d;
  logic [CNTW-1:0]              cnt_q, cnt_d;
  logic [IW-1:0]                pidx_q, pidx_d;
  logic [IW-1:0]                sidx_q, sidx_d;
  logic [MW-1:0]                pmode_q, pmode_d;
  logic [NUM_SLOTS-1:0]         used_q, used_d;
  logic                         done_q, done_d;
  logic                         acc_q, acc_d;
  logic [ptrt_pkg::SLOT_W-1:0]  rslot_q, rslot_d;
  logic [HW-1:0]                rhdl_q, rhdl_d;

  logic          accept;
  logic [IW-1:0] slot_idx;
  logic          in_range;
  logic [MW-1:0] rd_mode;
  logic [CW-1:0] rd_cd;
  logic [CW-1:0] rd_per;
  logic [HW-1:0] rd_hdl;
  logic          last_step;
  logic          pv;
  logic          p_used;
  logic          tick_hit;
  logic          disp_hit;
  logic [CW-1:0] cd_base;
  logic [CW-1:0] cd_next;
  logic [MW-1:0] tick_mode;

  // Decode of the command and of the entry read last cycle
  assign accept    = start_i && (state_q == ST_IDLE);
  assign slot_idx  = IW'(slot_i);
  assign in_range  = 32'(slot_i) < NUM_SLOTS;
  assign rd_mode   = rdata_a_i[MW+CW-1:CW];
  assign rd_cd     = rdata_a_i[CW-1:0];
  assign rd_per    = rdata_b_i[CW+HW-1:HW];
  assign rd_hdl    = rdata_b_i[HW-1:0];
  assign last_step = (cnt_q == CNTW'(NUM_SLOTS));
  assign pv        = (cnt_q != '0);
  assign p_used    = used_q[pidx_q];
  assign tick_hit  = p_used && (rd_mode == ptrt_pkg::MODE_WAITING);
  assign disp_hit  = p_used && (rd_mode == ptrt_pkg::MODE_READY);
  // countdown at zero reloads the period, then always counts down
  assign cd_base   = (rd_cd == '0) ? rd_per : rd_cd;
  assign cd_next   = cd_base - CW'(1);
  assign tick_mode = (rd_cd == '0) ? ptrt_pkg::MODE_READY : ptrt_pkg::MODE_WAITING;

  // Sequencer
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    pidx_d     = pidx_q;
    sidx_d     = sidx_q;
    pmode_d    = pmode_q;
    used_d     = used_q;
    done_d     = 1'b0;
    acc_d      = acc_q;
    rslot_d    = rslot_q;
    rhdl_d     = rhdl_q;
    mem_ctrl_o = '0;
    rd_addr_o  = cnt_q[IW-1:0];
    wr_addr_o  = pidx_q;
    wdata_a_o  = '0;
    wdata_b_o  = {CW'(period_i), task_handle_i};

    case (state_q)
      ST_IDLE: begin
        rd_addr_o = slot_idx;
        if (accept) begin
          done_d  = 1'b1;
          acc_d   = 1'b1;
          rslot_d = '0;
          rhdl_d  = '0;
          case (operation_i)
            ptrt_pkg::OP_ADD: begin
              acc_d = 1'b0;
              if (in_range && !used_q[slot_idx]) begin
                acc_d            = 1'b1;
                used_d[slot_idx] = 1'b1;
                mem_ctrl_o.wr_a  = 1'b1;
                mem_ctrl_o.wr_b  = 1'b1;
                wr_addr_o        = slot_idx;
                wdata_a_o        = {ptrt_pkg::MODE_WAITING, CW'(0)};
              end
            end
            ptrt_pkg::OP_DELETE: begin
              if (in_range) begin
                used_d[slot_idx] = 1'b0;
              end
            end
            ptrt_pkg::OP_PEND, ptrt_pkg::OP_RESUME: begin
              // an unused slot's mode is rewritten by the next add anyway
              if (in_range && used_q[slot_idx]) begin
                done_d           = 1'b0;
                mem_ctrl_o.rd_en = 1'b1;
                state_d          = ST_PR;
                sidx_d           = slot_idx;
                pmode_d          = (operation_i == ptrt_pkg::OP_PEND) ?
                                   ptrt_pkg::MODE_PENDED : ptrt_pkg::MODE_WAITING;
              end
            end
            ptrt_pkg::OP_TICK: begin
              done_d  = 1'b0;
              state_d = ST_TICK;
              cnt_d   = '0;
            end
            ptrt_pkg::OP_DISPATCH: begin
              done_d  = 1'b0;
              acc_d   = 1'b0;
              state_d = ST_DISP;
              cnt_d   = '0;
            end
            default: begin
              acc_d = 1'b0;
            end
          endcase
        end
      end

      ST_PR: begin
        // write back the mode, keep the countdown
        mem_ctrl_o.wr_a = 1'b1;
        wr_addr_o       = sidx_q;
        wdata_a_o       = {pmode_q, rd_cd};
        done_d          = 1'b1;
        state_d         = ST_IDLE;
      end

      ST_TICK: begin
        // read entry cnt, update entry cnt-1
        mem_ctrl_o.rd_en = !last_step;
        pidx_d           = cnt_q[IW-1:0];
        cnt_d            = cnt_q + CNTW'(1);
        if (pv && tick_hit) begin
          mem_ctrl_o.wr_a = 1'b1;
          wdata_a_o       = {tick_mode, cd_next};
        end
        if (last_step) begin
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end
      end

      ST_DISP: begin
        mem_ctrl_o.rd_en = !last_step;
        pidx_d           = cnt_q[IW-1:0];
        cnt_d            = cnt_q + CNTW'(1);
        if (pv && disp_hit) begin
          done_d  = 1'b1;
          state_d = ST_IDLE;
          acc_d   = 1'b1;
          rslot_d = ptrt_pkg::SLOT_W'(pidx_q);
          rhdl_d  = rd_hdl;
          // run-once task leaves the table
          if (rd_per == '0) begin
            used_d[pidx_q] = 1'b0;
          end else begin
            mem_ctrl_o.wr_a = 1'b1;
            wdata_a_o       = {ptrt_pkg::MODE_WAITING, rd_cd};
          end
        end else if (last_step) begin
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      used_q  <= '0;
      done_q  <= 1'b0;
      acc_q   <= 1'b0;
      rslot_q <= '0;
      rhdl_q  <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      used_q  <= used_d;
      done_q  <= done_d;
      acc_q   <= acc_d;
      rslot_q <= rslot_d;
      rhdl_q  <= rhdl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pidx_q  <= pidx_d;
    sidx_q  <= sidx_d;
    pmode_q <= pmode_d;
  end

  assign busy_o         = (state_q != ST_IDLE);
  assign done_o         = done_q;
  assign accepted_o     = acc_q;
  assign ready_slot_o   = rslot_q;
  assign ready_handle_o = rhdl_q;

endmodule

`default_nettype wire

// ----- rtl/periodic_task_ready_table.sv -----
// Top level of the periodic task ready table.
//
// Commands: drive operation_i, slot_i, period_i and task_handle_i and raise
// start; the item is taken at a clock edge where start is high and busy is
// low. Each item gives exactly one result on accepted_o, ready_slot_o and
// ready_handle_o, shown for one cycle with done_o high; there is no way
// to hold it off, so the receiver must take it then.
// Steps from the accepting edge to the strobe cycle:
//   add, delete, unknown code, pend/resume of an unused or bad slot: answered at once
//   pend, resume of a used slot: read, then write back of the mode
//   tick: a sweep over all slots, one slot read per cycle from the slot memories
//   dispatch: a sweep in slot order up to the first ready slot, or over all if none
// The sweep is bound by the single read port of the slot memories. busy
// falls with the strobe, so the next item can be taken during that cycle.
// Reset clears the occupied bits (flip-flops) at once; the memories need no
// clearing, since an unoccupied slot's stored fields are never used.
`default_nettype none

module periodic_task_ready_table #(
  parameter int NUM_SLOTS   = 16,
  parameter int COUNT_WIDTH = 16
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           start,
  output logic                          busy,
  input  wire [ptrt_pkg::OP_W-1:0]      operation_i,
  input  wire [ptrt_pkg::SLOT_W-1:0]    slot_i,
  input  wire [ptrt_pkg::PERIOD_W-1:0]  period_i,
  input  wire [ptrt_pkg::HANDLE_W-1:0]  task_handle_i,
  output logic                          done_o,
  output logic                          accepted_o,
  output logic [ptrt_pkg::SLOT_W-1:0]   ready_slot_o,
  output logic [ptrt_pkg::HANDLE_W-1:0] ready_handle_o
);

  localparam int IW = $clog2(NUM_SLOTS);
  localparam int AW = ptrt_pkg::MODE_W + COUNT_WIDTH;
  localparam int BW = COUNT_WIDTH + ptrt_pkg::HANDLE_W;

  ptrt_pkg::mem_ctrl_t mem_ctrl;
  logic [IW-1:0]       rd_addr;
  logic [IW-1:0]       wr_addr;
  logic [AW-1:0]       wdata_a;
  logic [BW-1:0]       wdata_b;
  logic [AW-1:0]       rdata_a;
  logic [BW-1:0]       rdata_b;

  // Sequencer
  ptrt_ctrl #(
    .NUM_SLOTS   (NUM_SLOTS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .operation_i    (operation_i),
    .slot_i         (slot_i),
    .period_i       (period_i),
    .task_handle_i  (task_handle_i),
    .busy_o         (busy),
    .done_o         (done_o),
    .accepted_o     (accepted_o),
    .ready_slot_o   (ready_slot_o),
    .ready_handle_o (ready_handle_o),
    .mem_ctrl_o     (mem_ctrl),
    .rd_addr_o      (rd_addr),
    .wr_addr_o      (wr_addr),
    .wdata_a_o      (wdata_a),
    .wdata_b_o      (wdata_b),
    .rdata_a_i      (rdata_a),
    .rdata_b_i      (rdata_b)
  );

  // Slot memories
  ptrt_slot_mem #(
    .NUM_SLOTS   (NUM_SLOTS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_mem (
    .clk_i      (clk_i),
    .mem_ctrl_i (mem_ctrl),
    .rd_addr_i  (rd_addr),
    .wr_addr_i  (wr_addr),
    .wdata_a_i  (wdata_a),
    .wdata_b_i  (wdata_b),
    .rdata_a_o  (rdata_a),
    .rdata_b_o  (rdata_b)
  );

  // The strobe cycle is always one where a new item can be taken
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  // Add and delete answer in the next cycle
  a_fast_ops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (operation_i == ptrt_pkg::OP_ADD ||
                        operation_i == ptrt_pkg::OP_DELETE)) |=> done_o)
    else $error("add or delete result missing");

  // A rejected item reports no slot and no handle
  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !accepted_o) |-> (ready_slot_o == '0 && ready_handle_o == '0))
    else $error("rejected result carries slot or handle");

  // busy only rises after an item was taken
  a_busy_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start))
    else $error("busy without a command");

endmodule

`default_nettype wire
